@@ src/four_point_marker_labeler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the four point marker labeler
// Concurrent checks clocked on clk; one form with the reset guard, one without.
// ----------------------------------------------------------------------------
`ifndef FOUR_POINT_MARKER_LABELER_MACROS_SVH
`define FOUR_POINT_MARKER_LABELER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check guarded by reset.
`define FPML_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fpml assertion failed");

// Check that also holds while reset is high.
`define FPML_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fpml assertion failed");

`else

`define FPML_ASSERT(lbl, prop)
`define FPML_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ src/fpml_pkg.sv @@
// ----------------------------------------------------------------------------
// fpml_pkg
// Shared types and constants of the four point marker labeler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpml_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int NUM_POINTS         = 4;
  localparam int NUM_PAIRS          = 6;

  typedef logic [1:0] pt_idx_t;
  typedef logic [2:0] pair_idx_t;
  typedef logic [1:0] score_t;

  // pair order 12,13,14,23,42,43 (one based points)
  localparam pt_idx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd3, 2'd3};
  localparam pt_idx_t PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd2};

  // scores always add up to 2+2+1+1
  localparam logic [3:0] SCORE_SUM = 4'd6;

endpackage

`default_nettype wire

@@ src/fpml_points_if.sv @@
// ----------------------------------------------------------------------------
// fpml_points_if
// Input channel: one set of four detected points per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpml_points_if
  import fpml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point1_x;
  logic [COORD_BITS-1:0] point1_y;
  logic [COORD_BITS-1:0] point2_x;
  logic [COORD_BITS-1:0] point2_y;
  logic [COORD_BITS-1:0] point3_x;
  logic [COORD_BITS-1:0] point3_y;
  logic [COORD_BITS-1:0] point4_x;
  logic [COORD_BITS-1:0] point4_y;

  modport source (
    output valid, point1_x, point1_y, point2_x, point2_y,
           point3_x, point3_y, point4_x, point4_y,
    input  ready
  );

  modport sink (
    input  valid, point1_x, point1_y, point2_x, point2_y,
           point3_x, point3_y, point4_x, point4_y,
    output ready
  );

endinterface

`default_nettype wire

@@ src/fpml_labels_if.sv @@
// ----------------------------------------------------------------------------
// fpml_labels_if
// Output channel: four labeled slots and a validity flag per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpml_labels_if
  import fpml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] slot0_x;
  logic [COORD_BITS-1:0] slot0_y;
  logic [COORD_BITS-1:0] slot1_x;
  logic [COORD_BITS-1:0] slot1_y;
  logic [COORD_BITS-1:0] slot2_x;
  logic [COORD_BITS-1:0] slot2_y;
  logic [COORD_BITS-1:0] slot3_x;
  logic [COORD_BITS-1:0] slot3_y;
  logic                  labels_valid;

  modport source (
    output valid, slot0_x, slot0_y, slot1_x, slot1_y,
           slot2_x, slot2_y, slot3_x, slot3_y, labels_valid,
    input  ready
  );

  modport sink (
    input  valid, slot0_x, slot0_y, slot1_x, slot1_y,
           slot2_x, slot2_y, slot3_x, slot3_y, labels_valid,
    output ready
  );

endinterface

`default_nettype wire

@@ src/fpml_dist.sv @@
// ----------------------------------------------------------------------------
// fpml_dist
// Input stage: registers the four points and their six squared distances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpml_dist
  import fpml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  fpml_points_if.sink        points,
  input  wire logic          advance,
  output logic               stage_valid,
  output logic [COORD_BITS-1:0] px [NUM_POINTS],
  output logic [COORD_BITS-1:0] py [NUM_POINTS],
  output logic [2*COORD_BITS:0] pair_dist [NUM_PAIRS]
);

  logic [COORD_BITS-1:0] in_x [NUM_POINTS];
  logic [COORD_BITS-1:0] in_y [NUM_POINTS];
  logic [2*COORD_BITS:0] pair_dist_next [NUM_PAIRS];

  assign in_x[0] = points.point1_x;
  assign in_y[0] = points.point1_y;
  assign in_x[1] = points.point2_x;
  assign in_y[1] = points.point2_y;
  assign in_x[2] = points.point3_x;
  assign in_y[2] = points.point3_y;
  assign in_x[3] = points.point4_x;
  assign in_y[3] = points.point4_y;

  assign points.ready = !stage_valid || advance;

  always_comb begin
    logic [COORD_BITS-1:0]   ax, ay, bx, by, dx, dy;
    logic [2*COORD_BITS-1:0] sx, sy;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      ax = in_x[PAIR_A[k]];
      ay = in_y[PAIR_A[k]];
      bx = in_x[PAIR_B[k]];
      by = in_y[PAIR_B[k]];
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      sx = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
      sy = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
      pair_dist_next[k] = {1'b0, sx} + {1'b0, sy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (points.ready) begin
      stage_valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      px        <= in_x;
      py        <= in_y;
      pair_dist <= pair_dist_next;
    end
  end

endmodule

`default_nettype wire

@@ src/four_point_marker_labeler.sv @@
// ----------------------------------------------------------------------------
// four_point_marker_labeler
// Labels four points by the longest and shortest of their pairwise distances.
//
//   channel  modport  transaction
//   points   sink     four points, x and y each
//   labels   source   slots 0..3 (x, y) and labels_valid
//
// One set of points per cycle unless the output stalls; both stages register each set.
// The first stage holds the squared distances, the second the labeled slots.
// Both stages advance together; a stalled output holds and the input stage
// still fills, so points.ready drops only when both stages are full.
// Reset clears the stage valid flags only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "four_point_marker_labeler_macros.svh"

module four_point_marker_labeler
  import fpml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  fpml_points_if.sink   points,
  fpml_labels_if.source labels
);

  logic                  advance;
  logic                  stage_valid;
  logic [COORD_BITS-1:0] px [NUM_POINTS];
  logic [COORD_BITS-1:0] py [NUM_POINTS];
  logic [2*COORD_BITS:0] pair_dist [NUM_PAIRS];

  logic [2*COORD_BITS:0] max_val [3];
  logic [2*COORD_BITS:0] min_val [3];
  pair_idx_t             max_idx [3];
  pair_idx_t             min_idx [3];
  logic [2*COORD_BITS:0] max_mid, min_mid;
  pair_idx_t             max_mid_idx, min_mid_idx;
  pair_idx_t             imax, imin;
  logic [2*COORD_BITS:0] dmax, dmin;
  score_t                score [NUM_POINTS];
  logic [COORD_BITS-1:0] slot_x_next [NUM_POINTS];
  logic [COORD_BITS-1:0] slot_y_next [NUM_POINTS];
  logic [NUM_POINTS-1:0] filled;

  fpml_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .points      (points),
    .advance     (advance),
    .stage_valid (stage_valid),
    .px          (px),
    .py          (py),
    .pair_dist   (pair_dist)
  );

  assign advance = !labels.valid || labels.ready;

  // extremes by a small tree; the later pair wins ties
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (pair_dist[2*j+1] >= pair_dist[2*j]) begin
        max_val[j] = pair_dist[2*j+1];
        max_idx[j] = pair_idx_t'(2*j+1);
      end else begin
        max_val[j] = pair_dist[2*j];
        max_idx[j] = pair_idx_t'(2*j);
      end
      if (pair_dist[2*j+1] <= pair_dist[2*j]) begin
        min_val[j] = pair_dist[2*j+1];
        min_idx[j] = pair_idx_t'(2*j+1);
      end else begin
        min_val[j] = pair_dist[2*j];
        min_idx[j] = pair_idx_t'(2*j);
      end
    end
    if (max_val[1] >= max_val[0]) begin
      max_mid     = max_val[1];
      max_mid_idx = max_idx[1];
    end else begin
      max_mid     = max_val[0];
      max_mid_idx = max_idx[0];
    end
    if (min_val[1] <= min_val[0]) begin
      min_mid     = min_val[1];
      min_mid_idx = min_idx[1];
    end else begin
      min_mid     = min_val[0];
      min_mid_idx = min_idx[0];
    end
    if (max_val[2] >= max_mid) begin
      dmax = max_val[2];
      imax = max_idx[2];
    end else begin
      dmax = max_mid;
      imax = max_mid_idx;
    end
    if (min_val[2] <= min_mid) begin
      dmin = min_val[2];
      imin = min_idx[2];
    end else begin
      dmin = min_mid;
      imin = min_mid_idx;
    end
  end

  // scoring and slot routing; higher point index wins a shared score
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      score[i] = {(PAIR_A[imax] == pt_idx_t'(i)) || (PAIR_B[imax] == pt_idx_t'(i)),
                  (PAIR_A[imin] == pt_idx_t'(i)) || (PAIR_B[imin] == pt_idx_t'(i))};
    end
    for (int s = 0; s < NUM_POINTS; s++) begin
      slot_x_next[s] = '0;
      slot_y_next[s] = '0;
      filled[s]      = 1'b0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (score[i] == score_t'(s)) begin
          slot_x_next[s] = px[i];
          slot_y_next[s] = py[i];
          filled[s]      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      labels.valid <= 1'b0;
    end else if (advance) begin
      labels.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      labels.slot0_x      <= slot_x_next[0];
      labels.slot0_y      <= slot_y_next[0];
      labels.slot1_x      <= slot_x_next[1];
      labels.slot1_y      <= slot_y_next[1];
      labels.slot2_x      <= slot_x_next[2];
      labels.slot2_y      <= slot_y_next[2];
      labels.slot3_x      <= slot_x_next[3];
      labels.slot3_y      <= slot_y_next[3];
      labels.labels_valid <= &filled;
    end
  end

  `FPML_ASSERT_ALWAYS(a_reset_empties, rst |=> (!labels.valid && !stage_valid))
  `FPML_ASSERT(a_full_when_blocked,
    !points.ready |-> (stage_valid && labels.valid && !labels.ready))
  `FPML_ASSERT(a_same_pair_only_when_flat, (stage_valid && imax == imin) |-> (dmax == dmin))
  `FPML_ASSERT(a_score_sum, stage_valid |->
    ({2'b00, score[0]} + {2'b00, score[1]} + {2'b00, score[2]} + {2'b00, score[3]}
      == SCORE_SUM))

endmodule

`default_nettype wire

@@ tb/tb_four_point_marker_labeler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_point_marker_labeler
// Drives sets of four points into the labeler and checks every labels
// transaction against a local model of the distance scoring. A directed
// table covers extremes, ties and shared scores; random point sets follow,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------

module tb_four_point_marker_labeler;
  import fpml_pkg::*;

  localparam int CW       = COORD_BITS_DEFAULT;
  localparam int CMAX     = (1 << CW) - 1;
  localparam int N_RANDOM = 600;
  localparam int IDLE_MAX = 2000;
  localparam int N_DIR    = 16;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
  } point_set_t;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
    logic               ok;
  } label_set_t;

  // typed, p1x, p1y .. p4x, p4y, s0x, s0y .. s3x, s3y, labels_valid
  localparam int DIRECTED [N_DIR][18] = '{
    '{1, 0, 0, 0, 0, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
         1023, 1023, 0, 0, 0, 0, 1023, 1023, 0},
    '{1, 0, 0, 1023, 1023, 1, 0, 0, 3,  0, 3, 1, 0, 1023, 1023, 0, 0, 1},
    '{1, 0, 0, 1023, 0, 500, 1, 501, 1,  0, 0, 501, 1, 1023, 0, 0, 0, 0},
    '{0, 0, 0, 1023, 0, 1023, 1023, 0, 1023,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 100, 0, 100, 10, 0, 10,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 5, 5, 5, 5, 5, 5, 900, 900,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 1023, 1023, 1023, 1023,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 341, 0, 682, 0, 1023, 0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 682, 341, 341, 682, 0, 1023, 1023, 0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 512, 256, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 0, 1023, 0, 500, 500,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 10, 0, 20, 0, 30, 0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1023, 0, 0, 1023, 2, 4, 8, 16,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 32, 64, 128, 1023, 1023, 128, 64, 32,  0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1023, 1023, 0, 0, 1023, 1023,  0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  localparam int PT_A [6] = '{0, 0, 0, 1, 3, 3};
  localparam int PT_B [6] = '{1, 2, 3, 2, 1, 2};

  logic clk;
  logic rst;
  bit   steady;
  int   stall_left;
  int   idle_cycles;
  int   mismatches;
  int   checked;

  label_set_t labels_due [$];

  fpml_points_if #(.COORD_BITS(CW)) pts ();
  fpml_labels_if #(.COORD_BITS(CW)) lbl ();

  four_point_marker_labeler #(.COORD_BITS(CW)) uut (
    .clk    (clk),
    .rst    (rst),
    .points (pts),
    .labels (lbl)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic label_set_t label_points(input point_set_t p);
    logic [CW-1:0] dx, dy;
    logic [20:0]   d [6];
    logic [20:0]   dmin, dmax;
    logic [1:0]    score [4];
    bit            filled [4];
    int            imin, imax;
    label_set_t    r;
    r = '0;
    for (int k = 0; k < 6; k++) begin
      dx = (p.x[PT_A[k]] >= p.x[PT_B[k]]) ? p.x[PT_A[k]] - p.x[PT_B[k]]
                                          : p.x[PT_B[k]] - p.x[PT_A[k]];
      dy = (p.y[PT_A[k]] >= p.y[PT_B[k]]) ? p.y[PT_A[k]] - p.y[PT_B[k]]
                                          : p.y[PT_B[k]] - p.y[PT_A[k]];
      d[k] = 21'(dx) * 21'(dx) + 21'(dy) * 21'(dy);
    end
    dmin = d[0];
    dmax = d[0];
    for (int k = 1; k < 6; k++) begin
      if (d[k] < dmin) dmin = d[k];
      if (d[k] > dmax) dmax = d[k];
    end
    imin = 0;
    imax = 0;
    for (int k = 0; k < 6; k++) begin
      if (d[k] == dmin) imin = k;
      if (d[k] == dmax) imax = k;
    end
    for (int i = 0; i < 4; i++) begin
      score[i]  = 2'd0;
      filled[i] = 1'b0;
    end
    score[PT_A[imax]] += 2'd2;
    score[PT_B[imax]] += 2'd2;
    score[PT_A[imin]] += 2'd1;
    score[PT_B[imin]] += 2'd1;
    for (int i = 0; i < 4; i++) begin
      r.x[score[i]] = p.x[i];
      r.y[score[i]] = p.y[i];
      filled[score[i]] = 1'b1;
    end
    r.ok = filled[0] && filled[1] && filled[2] && filled[3];
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic point_set_t random_points();
    point_set_t p;
    int mode, bx, by, w, h, s, r, j;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      p.x[i] = CW'($urandom_range(0, CMAX));
      p.y[i] = CW'($urandom_range(0, CMAX));
    end
    case (mode)
      4, 5: begin
        bx = $urandom_range(0, CMAX - 3);
        by = $urandom_range(0, CMAX - 3);
        for (int i = 0; i < 4; i++) begin
          p.x[i] = CW'(bx + $urandom_range(0, 3));
          p.y[i] = CW'(by + $urandom_range(0, 3));
        end
      end
      6: begin
        for (int i = 0; i < 4; i++) begin
          p.x[i] = $urandom_range(0, 1) ? CW'(CMAX) : '0;
          p.y[i] = $urandom_range(0, 1) ? CW'(CMAX) : '0;
        end
      end
      7: begin
        r = $urandom_range(0, 3);
        j = $urandom_range(0, 3);
        p.x[j] = p.x[r];
        p.y[j] = p.y[r];
      end
      8: begin
        bx = $urandom_range(0, CMAX);
        by = $urandom_range(0, CMAX);
        w  = $urandom_range(0, CMAX - bx);
        h  = $urandom_range(0, CMAX - by);
        r  = $urandom_range(0, 3);
        p.x[r]           = CW'(bx);
        p.y[r]           = CW'(by);
        p.x[(r + 1) % 4] = CW'(bx + w);
        p.y[(r + 1) % 4] = CW'(by);
        p.x[(r + 2) % 4] = CW'(bx + w);
        p.y[(r + 2) % 4] = CW'(by + h);
        p.x[(r + 3) % 4] = CW'(bx);
        p.y[(r + 3) % 4] = CW'(by + h);
      end
      9: begin
        s  = $urandom_range(0, CMAX / 3);
        bx = $urandom_range(0, CMAX - 3 * s);
        by = $urandom_range(0, CMAX);
        for (int i = 0; i < 4; i++) begin
          p.x[i] = CW'(bx + i * s);
          p.y[i] = CW'(by);
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_points(input point_set_t p, input label_set_t due);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid    <= 1'b1;
    pts.point1_x <= p.x[0];
    pts.point1_y <= p.y[0];
    pts.point2_x <= p.x[1];
    pts.point2_y <= p.y[1];
    pts.point3_x <= p.x[2];
    pts.point3_y <= p.y[2];
    pts.point4_x <= p.x[3];
    pts.point4_y <= p.y[3];
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    labels_due.push_back(due);
  endtask

  task automatic drain_labels();
    pts.valid <= 1'b0;
    while (labels_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int slot, input int want,
                             input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on transaction %0d, %s slot %0d: expected %0d, got %0d",
                 checked, name, slot, want, got);
    end
  endtask

  // output stall generator
  always @(posedge clk) begin
    if (rst) begin
      lbl.ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      lbl.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      lbl.ready  <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      lbl.ready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    label_set_t got, want;
    if (!rst) begin
      if ((pts.valid && pts.ready) || (lbl.valid && lbl.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_MAX);
        $display("TEST FAILED");
        $finish;
      end
      if (lbl.valid && lbl.ready) begin
        got.x  = {lbl.slot3_x, lbl.slot2_x, lbl.slot1_x, lbl.slot0_x};
        got.y  = {lbl.slot3_y, lbl.slot2_y, lbl.slot1_y, lbl.slot0_y};
        got.ok = lbl.labels_valid;
        if (labels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("labels transaction with nothing pending");
        end else begin
          want = labels_due.pop_front();
          for (int k = 0; k < 4; k++) begin
            check_field("x", k, want.x[k], got.x[k]);
            check_field("y", k, want.y[k], got.y[k]);
          end
          check_field("labels_valid", 0, want.ok, got.ok);
        end
        checked++;
      end
    end
  end

  initial begin
    point_set_t p;
    label_set_t due;
    rst          = 1'b1;
    steady       = 1'b0;
    idle_cycles  = 0;
    mismatches   = 0;
    checked      = 0;
    pts.valid    <= 1'b0;
    pts.point1_x <= '0;
    pts.point1_y <= '0;
    pts.point2_x <= '0;
    pts.point2_y <= '0;
    pts.point3_x <= '0;
    pts.point3_y <= '0;
    pts.point4_x <= '0;
    pts.point4_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_DIR; n++) begin
      for (int i = 0; i < 4; i++) begin
        p.x[i] = CW'(DIRECTED[n][1 + 2 * i]);
        p.y[i] = CW'(DIRECTED[n][2 + 2 * i]);
      end
      if (DIRECTED[n][0] != 0) begin
        for (int i = 0; i < 4; i++) begin
          due.x[i] = CW'(DIRECTED[n][9 + 2 * i]);
          due.y[i] = CW'(DIRECTED[n][10 + 2 * i]);
        end
        due.ok = DIRECTED[n][17][0];
      end else begin
        due = label_points(p);
      end
      send_points(p, due);
    end
    drain_labels();

    for (int blk = 0; blk < N_RANDOM / 60; blk++) begin
      steady = (blk % 4 == 2);
      for (int i = 0; i < 60; i++) begin
        p = random_points();
        send_points(p, label_points(p));
      end
    end
    steady = 1'b0;
    drain_labels();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && labels_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
